/* rtl/core/stereo_allpass_phase_rotator_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the stereo allpass phase rotator
// Shared concurrent-assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef STEREO_ALLPASS_PHASE_ROTATOR_DEFINES_SVH
`define STEREO_ALLPASS_PHASE_ROTATOR_DEFINES_SVH

// Same-cycle implication.
`define APR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apr: same-cycle check failed");

// Next-cycle implication.
`define APR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apr: next-cycle check failed");

`endif

/* rtl/core/apr_pkg.sv */
// ---------------------------------------------------------------------------
// apr_pkg
// Shared constants, types and register indexes of the allpass phase rotator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package apr_pkg;

  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_COEF_FRAC_BITS = 17;
  localparam int DEF_NUM_SECTIONS   = 4;

  localparam int COEF_WIDTH    = 18;
  localparam int STATE_BITS    = 32;
  localparam int NUM_COEF_REGS = 4;
  localparam int CFG_ADDR_W    = 3;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_ONE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_TWO   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_THREE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_FOUR  = 3'd3;

  // Reset coefficients: 120/180/240/300 Hz corners at 48 kHz, Q1.17
  localparam logic signed [COEF_WIDTH-1:0] COEF_RESET [NUM_COEF_REGS] = '{
    -18'sd129029, -18'sd128019, -18'sd127018, -18'sd126023
  };

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MUL_X,
    PH_ADD,
    PH_MUL_Y,
    PH_WRITE,
    PH_OUT
  } phase_t;

  // Per-cycle controls from the sequencer
  typedef struct packed {
    logic load_x;      // load chain input sample
    logic src_right;   // sample source: right hold register
    logic rd_en;       // state memory read
    logic mul_x;       // prod = c * x
    logic add_y;       // y = sat(rnd(prod) + s)
    logic mul_y;       // prod = c * y
    logic write_s;     // s' = sat(x - rnd(prod)), x <= y
    logic save_left;   // capture left chain result
    logic save_right;  // capture right chain result
    logic out_load;    // move results to output register
  } dp_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/stereo_allpass_phase_rotator.sv */
// Stereo allpass phase rotator - usage
// Input stream (in_*): one stereo sample pair per item; in_tdata carries
//   left_in and right_in, in_tuser carries stereo_flag (0 = mono: the right
//   sample passes through and the right chain state is kept).
// Output stream (out_*): one item per input item, in order, with left_out and
//   right_out, each saturated to SAMPLE_BITS.
// Config port (cfg_*): writes one of four Q1.17 section coefficients; write
//   only while the block is idle. Indexes past the fourth register are ignored.
// Each section runs its phases on the shared multiplier in order: c*x, add
//   state, c*y, state write-back.
// Items: a new item is accepted only while the sequencer is idle, after the
//   previous result has moved to the output register.
// Reset: coefficients return to the 48 kHz defaults (120/180/240/300 Hz) and
//   all section states read as zero; no clearing pass is needed.
// Stall: the output register holds a finished item while the next one is
//   accepted and processed; the sequencer waits at the end of that item until
//   the output register frees up.
// ---------------------------------------------------------------------------
// stereo_allpass_phase_rotator
// Four-section first-order allpass cascade per channel, state in memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_allpass_phase_rotator_defines.svh"

module stereo_allpass_phase_rotator #(
  parameter int SAMPLE_BITS    = apr_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = apr_pkg::DEF_COEF_FRAC_BITS,
  parameter int NUM_SECTIONS   = apr_pkg::DEF_NUM_SECTIONS,
  parameter int DATA_W         = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input item
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [DATA_W-1:0]                  in_tdata,   // left_in, right_in, zero pad
  input  wire logic [0:0]                         in_tuser,   // stereo_flag
  // result item
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [DATA_W-1:0]                       out_tdata,  // left_out, right_out, zero pad
  // coefficient writes
  input  wire logic                               cfg_wr_en,
  input  wire logic [apr_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  wire logic [apr_pkg::COEF_WIDTH-1:0]     cfg_wdata
);

  localparam int SEC_W  = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int MEM_AW = SEC_W + 1;

  apr_pkg::dp_ctrl_t ctl;

  logic                                   in_fire;
  logic                                   out_free;
  logic [SEC_W-1:0]                       sec;
  logic                                   chan;
  logic [SEC_W+1:0]                       sec_ext;
  logic [1:0]                             coef_idx;
  logic [MEM_AW-1:0]                      mem_addr;
  logic signed [SAMPLE_BITS-1:0]          in_left;
  logic signed [SAMPLE_BITS-1:0]          in_right;
  logic signed [SAMPLE_BITS-1:0]          ld_sample;
  logic signed [SAMPLE_BITS-1:0]          dp_y;
  logic signed [apr_pkg::STATE_BITS-1:0]  rd_data;
  logic signed [apr_pkg::STATE_BITS-1:0]  wr_data;

  logic signed [apr_pkg::COEF_WIDTH-1:0]  coef_r [apr_pkg::NUM_COEF_REGS];
  logic signed [SAMPLE_BITS-1:0]          left_r;
  logic signed [SAMPLE_BITS-1:0]          right_r;   // right input, then right result
  logic signed [SAMPLE_BITS-1:0]          out_left_r;
  logic signed [SAMPLE_BITS-1:0]          out_right_r;
  logic                                   out_tvalid_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign in_left  = in_tdata[SAMPLE_BITS-1:0];
  assign in_right = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  // section k uses coefficient register k mod 4
  assign sec_ext  = (SEC_W + 2)'(sec);
  assign coef_idx = sec_ext[1:0];

  // left chain in the lower half of the memory, right chain in the upper
  assign mem_addr  = {chan, sec};
  assign ld_sample = ctl.src_right ? right_r : in_left;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < apr_pkg::NUM_COEF_REGS; i++) begin
        coef_r[i] <= apr_pkg::COEF_RESET[i];
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        apr_pkg::REG_COEF_ONE:   coef_r[0] <= cfg_wdata;
        apr_pkg::REG_COEF_TWO:   coef_r[1] <= cfg_wdata;
        apr_pkg::REG_COEF_THREE: coef_r[2] <= cfg_wdata;
        apr_pkg::REG_COEF_FOUR:  coef_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  apr_ctrl #(
    .NUM_SECTIONS (NUM_SECTIONS),
    .SEC_W        (SEC_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_stereo (in_tuser[0]),
    .out_free  (out_free),
    .in_ready  (in_tready),
    .sec       (sec),
    .chan      (chan),
    .ctl       (ctl)
  );

  apr_state_mem #(
    .ADDR_W (MEM_AW),
    .DATA_W (apr_pkg::STATE_BITS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ctl.rd_en),
    .rd_addr (mem_addr),
    .rd_data (rd_data),
    .wr_en   (ctl.write_s),
    .wr_addr (mem_addr),
    .wr_data (wr_data)
  );

  apr_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .ctl       (ctl),
    .coef      (coef_r[coef_idx]),
    .ld_sample (ld_sample),
    .rd_data   (rd_data),
    .y         (dp_y),
    .wr_data   (wr_data)
  );

  // result holding registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      right_r <= in_right;
    end else if (ctl.save_right) begin
      right_r <= dp_y;
    end
    if (ctl.save_left) begin
      left_r <= dp_y;
    end
    if (ctl.out_load) begin
      out_left_r  <= left_r;
      out_right_r <= right_r;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DATA_W'({out_right_r, out_left_r});

  // an accepted item keeps the input closed on the next cycle
  `APR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_tready)
  // output register only reloaded when empty or being drained
  `APR_ASSERT_NOW(a_out_load_free, clk, rst_n, ctl.out_load, out_free)
  // no state read and write-back in the same cycle
  `APR_ASSERT_NOW(a_mem_port_excl, clk, rst_n, ctl.rd_en, !ctl.write_s)
  // a result is captured only at the last section's write-back
  `APR_ASSERT_NOW(a_save_at_write, clk, rst_n, ctl.save_left || ctl.save_right,
                  ctl.write_s && (sec == SEC_W'(NUM_SECTIONS - 1)))

endmodule

`default_nettype wire

/* rtl/core/apr_state_mem.sv */
// ---------------------------------------------------------------------------
// apr_state_mem
// Section state memory: one write port, one registered read port, per-entry
// valid bits so unwritten entries read as zero after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apr_state_mem #(
  parameter int ADDR_W = 3,
  parameter int DATA_W = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     rd_en,
  input  wire logic [ADDR_W-1:0]        rd_addr,
  output logic signed [DATA_W-1:0]      rd_data,
  input  wire logic                     wr_en,
  input  wire logic [ADDR_W-1:0]        wr_addr,
  input  wire logic signed [DATA_W-1:0] wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         valid_r;
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

`default_nettype wire

/* rtl/core/apr_datapath.sv */
// ---------------------------------------------------------------------------
// apr_datapath
// Shared multiply / round / add datapath for one allpass section step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apr_datapath #(
  parameter int SAMPLE_BITS    = apr_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = apr_pkg::DEF_COEF_FRAC_BITS
) (
  input  wire logic                                       clk,
  input  wire apr_pkg::dp_ctrl_t                          ctl,
  input  wire logic signed [apr_pkg::COEF_WIDTH-1:0]      coef,
  input  wire logic signed [SAMPLE_BITS-1:0]              ld_sample,
  input  wire logic signed [apr_pkg::STATE_BITS-1:0]      rd_data,
  output logic signed [SAMPLE_BITS-1:0]                   y,
  output logic signed [apr_pkg::STATE_BITS-1:0]           wr_data
);

  localparam int PW = apr_pkg::COEF_WIDTH + SAMPLE_BITS;
  localparam int RW = PW + 1;
  localparam int AW = ((RW > apr_pkg::STATE_BITS) ? RW : apr_pkg::STATE_BITS) + 1;
  localparam int SB = apr_pkg::STATE_BITS;

  localparam logic signed [RW-1:0] HALF = {{(RW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SB-1:0] TMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] TMIN = {1'b1, {(SB-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [SAMPLE_BITS-1:0] mul_src;
  logic signed [RW-1:0]          rnd;
  logic signed [AW-1:0]          y_sum;
  logic signed [AW-1:0]          s_diff;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  assign mul_src = ctl.mul_y ? y_r : x_r;

  // round half up: floor((p + 2^(F-1)) / 2^F)
  assign rnd    = (RW'(prod_r) + HALF) >>> COEF_FRAC_BITS;
  assign y_sum  = AW'(rnd) + AW'(rd_data);
  assign s_diff = AW'(x_r) - AW'(rnd);

  always_comb begin
    if (y_sum > AW'(SMAX)) begin
      y_sat = SMAX;
    end else if (y_sum < AW'(SMIN)) begin
      y_sat = SMIN;
    end else begin
      y_sat = y_sum[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    if (s_diff > AW'(TMAX)) begin
      wr_data = TMAX;
    end else if (s_diff < AW'(TMIN)) begin
      wr_data = TMIN;
    end else begin
      wr_data = s_diff[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_x || ctl.mul_y) begin
      prod_r <= PW'(coef) * PW'(mul_src);
    end
    if (ctl.add_y) begin
      y_r <= y_sat;
    end
    if (ctl.load_x) begin
      x_r <= ld_sample;
    end else if (ctl.write_s) begin
      x_r <= y_r;
    end
  end

  assign y = y_r;

endmodule

`default_nettype wire

/* rtl/core/apr_ctrl.sv */
// ---------------------------------------------------------------------------
// apr_ctrl
// Section sequencer: walks sections and channels, four phases per section.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apr_ctrl #(
  parameter int NUM_SECTIONS = apr_pkg::DEF_NUM_SECTIONS,
  parameter int SEC_W        = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic             in_stereo,
  input  wire logic             out_free,
  output logic                  in_ready,
  output logic [SEC_W-1:0]      sec,
  output logic                  chan,
  output apr_pkg::dp_ctrl_t     ctl
);

  localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(NUM_SECTIONS - 1);

  apr_pkg::phase_t  state_r, state_nxt;
  logic [SEC_W-1:0] sec_r, sec_nxt;
  logic             chan_r, chan_nxt;
  logic             stereo_r, stereo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= apr_pkg::PH_IDLE;
      sec_r    <= '0;
      chan_r   <= 1'b0;
      stereo_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sec_r    <= sec_nxt;
      chan_r   <= chan_nxt;
      stereo_r <= stereo_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    sec_nxt    = sec_r;
    chan_nxt   = chan_r;
    stereo_nxt = stereo_r;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state_r)
      apr_pkg::PH_IDLE: begin
        // no item taken while reset is held
        in_ready = rst_n;
        if (in_fire) begin
          ctl.load_x = 1'b1;
          sec_nxt    = '0;
          chan_nxt   = 1'b0;
          stereo_nxt = in_stereo;
          state_nxt  = apr_pkg::PH_MUL_X;
        end
      end
      apr_pkg::PH_MUL_X: begin
        ctl.rd_en = 1'b1;
        ctl.mul_x = 1'b1;
        state_nxt = apr_pkg::PH_ADD;
      end
      apr_pkg::PH_ADD: begin
        ctl.add_y = 1'b1;
        state_nxt = apr_pkg::PH_MUL_Y;
      end
      apr_pkg::PH_MUL_Y: begin
        ctl.mul_y = 1'b1;
        state_nxt = apr_pkg::PH_WRITE;
      end
      apr_pkg::PH_WRITE: begin
        ctl.write_s = 1'b1;
        if (sec_r == LAST_SEC) begin
          if (!chan_r) begin
            ctl.save_left = 1'b1;
            if (stereo_r) begin
              // right chain starts from the held right sample
              ctl.load_x    = 1'b1;
              ctl.src_right = 1'b1;
              chan_nxt      = 1'b1;
              sec_nxt       = '0;
              state_nxt     = apr_pkg::PH_MUL_X;
            end else begin
              state_nxt = apr_pkg::PH_OUT;
            end
          end else begin
            ctl.save_right = 1'b1;
            state_nxt      = apr_pkg::PH_OUT;
          end
        end else begin
          sec_nxt   = sec_r + 1'b1;
          state_nxt = apr_pkg::PH_MUL_X;
        end
      end
      apr_pkg::PH_OUT: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = apr_pkg::PH_IDLE;
        end
      end
      default: begin
        state_nxt = apr_pkg::PH_IDLE;
      end
    endcase
  end

  assign sec  = sec_r;
  assign chan = chan_r;

endmodule

`default_nettype wire

/* verif/stereo_allpass_phase_rotator_test.sv */
// ---------------------------------------------------------------------------
// stereo_allpass_phase_rotator_test
// Self-checking bench for the four-section allpass phase rotator: drives
// stereo and mono sample pairs in random bursts, stalls the result side on
// its own pattern, and compares every result with a bit-true fixed-point
// model of both section chains across several coefficient settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_allpass_phase_rotator_test;
  import apr_pkg::*;

  localparam int SAMPLE_BITS    = DEF_SAMPLE_BITS;
  localparam int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS;
  localparam int NUM_SECTIONS   = DEF_NUM_SECTIONS;
  localparam int DATA_W         = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  // Cycles with neither an accept nor a result before the run is declared hung.
  // The limit lies far above the slowest gap between two of those: one stereo
  // item plus the longest receiver stall plus the longest sender gap.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet time after the last result, about three stereo items.
  localparam int TAIL_CYCLES    = 3 * (8 * NUM_SECTIONS + 2);
  localparam int PHASE_COUNT    = 8;
  localparam int ITEMS_PER_PHASE = 125;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEF_WIDTH-1:0]  COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic [COEF_WIDTH-1:0]  COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  typedef struct {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
  } rotated_pair_t;

  // -------------------------------------------------------------------------
  // Scoreboard: its own copy of coefficients and section states, a queue of
  // rotated pairs still owed by the block.
  // -------------------------------------------------------------------------
  class rotator_scoreboard;
    longint        coef [NUM_COEF_REGS];
    longint        section_state [2 * NUM_SECTIONS];
    rotated_pair_t owed_pairs [$];
    int            failures;

    function new();
      for (int i = 0; i < NUM_COEF_REGS; i++) coef[i] = longint'(COEF_RESET[i]);
      for (int i = 0; i < 2 * NUM_SECTIONS; i++) section_state[i] = 0;
      failures = 0;
    endfunction

    function automatic longint clamp(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // c*v in Q1.F, rounded half up (arithmetic shift floors)
    function automatic longint scale_by_coef(longint c, longint v);
      longint p;
      p = c * v + (longint'(1) <<< (COEF_FRAC_BITS - 1));
      return p >>> COEF_FRAC_BITS;
    endfunction

    // Transposed DF-II cascade; section k uses register k mod 4
    function automatic longint rotate_chain(longint x, int base);
      longint c;
      longint y;
      for (int k = 0; k < NUM_SECTIONS; k++) begin
        c = coef[k % NUM_COEF_REGS];
        y = clamp(scale_by_coef(c, x) + section_state[base + k], SAMPLE_BITS);
        section_state[base + k] = clamp(x - scale_by_coef(c, y), STATE_BITS);
        x = y;
      end
      return x;
    endfunction

    function void write_coef(logic [CFG_ADDR_W-1:0] idx, logic [COEF_WIDTH-1:0] val);
      if (idx < NUM_COEF_REGS) coef[idx] = longint'($signed(val));
    endfunction

    function void note_pair(logic [SAMPLE_BITS-1:0] left, logic [SAMPLE_BITS-1:0] right,
                            logic stereo);
      rotated_pair_t owed;
      longint        l_val;
      longint        r_val;
      l_val = rotate_chain(longint'($signed(left)), 0);
      r_val = longint'($signed(right));
      // mono: right sample and right chain state untouched
      if (stereo) r_val = rotate_chain(r_val, NUM_SECTIONS);
      owed.left  = l_val[SAMPLE_BITS-1:0];
      owed.right = r_val[SAMPLE_BITS-1:0];
      owed_pairs.push_back(owed);
    endfunction

    function void check_result(logic [DATA_W-1:0] data);
      rotated_pair_t owed;
      logic [SAMPLE_BITS-1:0] got_left;
      logic [SAMPLE_BITS-1:0] got_right;
      got_left  = data[SAMPLE_BITS-1:0];
      got_right = data[2*SAMPLE_BITS-1:SAMPLE_BITS];
      if (owed_pairs.size() == 0) begin
        $error("result with nothing owed: left_out %0d right_out %0d",
               $signed(got_left), $signed(got_right));
        failures++;
        return;
      end
      owed = owed_pairs.pop_front();
      if (got_left !== owed.left) begin
        $error("left_out: expected %0d, got %0d", $signed(owed.left), $signed(got_left));
        failures++;
      end
      if (got_right !== owed.right) begin
        $error("right_out: expected %0d, got %0d", $signed(owed.right), $signed(got_right));
        failures++;
      end
    endfunction

    function int outstanding();
      return owed_pairs.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, block under test
  // -------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata   = '0;   // left_in, right_in
  logic [0:0]             in_tuser   = '0;   // stereo_flag
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [DATA_W-1:0]      out_tdata;         // left_out, right_out
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_index  = '0;
  logic [COEF_WIDTH-1:0]  cfg_wdata  = '0;

  rotator_scoreboard board = new();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stereo_allpass_phase_rotator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // -------------------------------------------------------------------------
  // Receiver: stall pattern of short and long stalls, short ready runs and
  // long clean stretches with no stall at all.
  // -------------------------------------------------------------------------
  int ready_run = 0;

  always @(posedge clk) begin
    if (ready_run == 0) begin
      case ($urandom_range(0, 7))
        0: begin
          out_tready <= 1'b0;
          ready_run = $urandom_range(20, 60);   // up to almost two stereo items
        end
        1, 2: begin
          out_tready <= 1'b0;
          ready_run = $urandom_range(1, 6);
        end
        3: begin
          out_tready <= 1'b1;
          ready_run = $urandom_range(100, 400);
        end
        default: begin
          out_tready <= 1'b1;
          ready_run = $urandom_range(1, 10);
        end
      endcase
    end else begin
      ready_run--;
    end
  end

  // -------------------------------------------------------------------------
  // Result check and watchdog. Inputs are noted by the sender task itself.
  // -------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them
  // -------------------------------------------------------------------------
  int burst_left  = 0;
  bit valid_held  = 1'b0;   // in_tvalid left high for the next item of a burst
  logic [SAMPLE_BITS-1:0] walk_left  = '0;
  logic [SAMPLE_BITS-1:0] walk_right = '0;

  task automatic send_pair(input logic [SAMPLE_BITS-1:0] left,
                           input logic [SAMPLE_BITS-1:0] right,
                           input logic stereo);
    if (burst_left == 0) begin
      // random gap before the burst, so valid never drops and rises in one step
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {right, left};
    in_tuser  <= stereo;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_pair(left, right, stereo);
    burst_left--;
    if (burst_left == 0) begin
      in_tvalid  <= 1'b0;
      valid_held = 1'b0;
    end else begin
      valid_held = 1'b1;
    end
  endtask

  // Hold off new items until every owed result has come back
  task automatic drain();
    if (valid_held) begin
      in_tvalid  <= 1'b0;
      valid_held = 1'b0;
    end
    burst_left = 0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(ref logic [SAMPLE_BITS-1:0] walk);
    logic [SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = SAMPLE_MAX;
      1:       s = SAMPLE_MIN;
      2:       s = '0;
      3:       s = SAMPLE_BITS'($signed($urandom_range(0, 510)) - 255);
      4, 5:    s = walk + SAMPLE_BITS'($signed($urandom_range(0, 8190)) - 4095);
      default: s = SAMPLE_BITS'($urandom);
    endcase
    walk = s;
    return s;
  endfunction

  task automatic send_random();
    logic [SAMPLE_BITS-1:0] l;
    logic [SAMPLE_BITS-1:0] r;
    l = pick_sample(walk_left);
    r = pick_sample(walk_right);
    send_pair(l, r, $urandom_range(0, 3) != 0);
  endtask

  // Writes all four coefficients; optionally also the unused indexes, which
  // the block must ignore. One write per cycle, enable held across them.
  task automatic load_coefs(input logic [COEF_WIDTH-1:0] c_one,
                            input logic [COEF_WIDTH-1:0] c_two,
                            input logic [COEF_WIDTH-1:0] c_three,
                            input logic [COEF_WIDTH-1:0] c_four,
                            input bit stray_writes);
    logic [CFG_ADDR_W-1:0] idx_list [$];
    logic [COEF_WIDTH-1:0] val_list [$];
    if (stray_writes) begin
      for (int i = NUM_COEF_REGS; i < (1 << CFG_ADDR_W); i++) begin
        idx_list.push_back(CFG_ADDR_W'(i));
        val_list.push_back(COEF_WIDTH'($urandom));
      end
    end
    idx_list.push_back(REG_COEF_ONE);   val_list.push_back(c_one);
    idx_list.push_back(REG_COEF_TWO);   val_list.push_back(c_two);
    idx_list.push_back(REG_COEF_THREE); val_list.push_back(c_three);
    idx_list.push_back(REG_COEF_FOUR);  val_list.push_back(c_four);
    for (int i = 0; i < idx_list.size(); i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_wdata <= val_list[i];
      @(posedge clk);
      board.write_coef(idx_list[i], val_list[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [COEF_WIDTH-1:0] any_coef();
    return COEF_WIDTH'($urandom);
  endfunction

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset coefficients: extremes of both samples, mono and
    // stereo, an impulse and its tail.
    send_pair('0, '0, 1'b1);
    send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_pair(SAMPLE_MAX, '0, 1'b1);
    repeat (3) send_pair('0, '0, 1'b1);
    send_pair(SAMPLE_BITS'(1), '1, 1'b1);
    send_pair('1, SAMPLE_BITS'(1), 1'b0);
    for (int i = 0; i < 4; i++)
      send_pair(i[0] ? SAMPLE_MIN : SAMPLE_MAX, i[0] ? SAMPLE_MAX : SAMPLE_MIN, 1'b1);
    drain();

    // Coefficients at +1.0: full-scale alternation pushes sections into
    // saturation; a mono item in between keeps the right state frozen.
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
    for (int i = 0; i < 6; i++)
      send_pair(i[0] ? SAMPLE_MIN : SAMPLE_MAX, i[0] ? SAMPLE_MAX : SAMPLE_MIN, i != 2);

    // Random phases, each with its own coefficient setting; the block is
    // drained before every change.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain();
      case (ph)
        0:       load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
        1:       load_coefs('0, '0, '0, '0, 1'b1);
        2:       load_coefs(COEF_MAX, COEF_MIN, '0, any_coef(), 1'b0);
        3:       load_coefs(COEF_RESET[0], COEF_RESET[1], COEF_RESET[2],
                            COEF_RESET[3], 1'b1);
        4:       load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
        default: load_coefs(any_coef(), any_coef(), any_coef(), any_coef(), 1'b1);
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // odd phases pause mid-phase until the block has handed back everything
        if (n == ITEMS_PER_PHASE / 2 && ph[0]) drain();
        send_random();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
